// ===== design/bbox_extrapolate_zone_overlap_assert.svh =====
// Assertion macros shared by the checker files of the zone overlap block.
// Needs nothing else; each macro expands to one labelled concurrent assertion.
`ifndef BBOX_EXTRAPOLATE_ZONE_OVERLAP_ASSERT_SVH
`define BBOX_EXTRAPOLATE_ZONE_OVERLAP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent ends.
`define BBZO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbzo: assertion failed");

// Consequent checked in the cycle after the antecedent ends.
`define BBZO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbzo: assertion failed");

`endif

// ===== design/bbzo_pkg.sv =====
// Package of the zone overlap block: widths, register codes, reset corners
// and the stage load structure. Depends on nothing.
package bbzo_pkg;

    localparam int COORD_WIDTH_DEF = 12;
    localparam int ID_WIDTH        = 16;
    localparam int SPEED_WIDTH     = 16;
    localparam int NUM_CORNERS     = 4;
    localparam int NUM_ZONE_REGS   = 2 * NUM_CORNERS;
    localparam int REG_IDX_WIDTH   = $clog2(NUM_ZONE_REGS);
    localparam int NUM_STAGES      = 5;

    typedef enum logic [REG_IDX_WIDTH-1:0] {
        REG_DL_X,
        REG_DL_Y,
        REG_DR_X,
        REG_DR_Y,
        REG_UR_X,
        REG_UR_Y,
        REG_UL_X,
        REG_UL_Y
    } zone_reg_t;

    localparam int RST_DL_X = 400;
    localparam int RST_DL_Y = 719;
    localparam int RST_DR_X = 880;
    localparam int RST_DR_Y = 719;
    localparam int RST_UR_X = 700;
    localparam int RST_UR_Y = 400;
    localparam int RST_UL_X = 580;
    localparam int RST_UL_Y = 400;

    typedef struct packed {
        logic ld_in;
        logic ld_ext;
        logic ld_mul;
        logic ld_sum;
        logic ld_out;
    } stage_ld_t;

endpackage

// ===== design/bbzo_zone.sv =====
// Zone corner registers and the values derived from them: axis ranges, edge
// normals, zone projections on each normal and the non-zero area flag. Uses bbzo_pkg.
module bbzo_zone #(
    parameter int CW = bbzo_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [bbzo_pkg::REG_IDX_WIDTH-1:0]   wr_index,
    input  logic [CW-1:0]                        wr_data,
    output logic [CW-1:0]                        x_lo,
    output logic [CW-1:0]                        x_hi,
    output logic [CW-1:0]                        y_lo,
    output logic [CW-1:0]                        y_hi,
    output logic signed [CW:0]                   norm_x [bbzo_pkg::NUM_CORNERS],
    output logic signed [CW:0]                   norm_y [bbzo_pkg::NUM_CORNERS],
    output logic [bbzo_pkg::NUM_CORNERS-1:0]     edge_live,
    output logic signed [2*CW+2:0]               proj_lo [bbzo_pkg::NUM_CORNERS],
    output logic signed [2*CW+2:0]               proj_hi [bbzo_pkg::NUM_CORNERS],
    output logic                                 area_nz
);

    localparam int NC  = bbzo_pkg::NUM_CORNERS;
    localparam int ZW  = CW + 1;
    localparam int PPW = 2 * CW + 2;
    localparam int PSW = 2 * CW + 3;
    localparam int AP  = 2 * CW;
    localparam int ASW = AP + 3;

    function automatic logic [CW-1:0] umin(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [CW-1:0] umax(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [PSW-1:0] smin(input logic signed [PSW-1:0] a,
                                                   input logic signed [PSW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [PSW-1:0] smax(input logic signed [PSW-1:0] a,
                                                   input logic signed [PSW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    logic [CW-1:0]           zx_reg [NC];
    logic [CW-1:0]           zy_reg [NC];
    logic signed [ZW-1:0]    zxs [NC];
    logic signed [ZW-1:0]    zys [NC];
    logic signed [ZW-1:0]    nx_next [NC];
    logic signed [ZW-1:0]    ny_next [NC];
    logic signed [ZW-1:0]    nx_reg [NC];
    logic signed [ZW-1:0]    ny_reg [NC];
    logic [NC-1:0]           live_reg;
    logic [CW-1:0]           xlo_reg;
    logic [CW-1:0]           xhi_reg;
    logic [CW-1:0]           ylo_reg;
    logic [CW-1:0]           yhi_reg;
    logic signed [PPW-1:0]   pzx_reg [NC][NC];
    logic signed [PPW-1:0]   pzy_reg [NC][NC];
    logic [AP-1:0]           ap_reg [NC];
    logic [AP-1:0]           an_reg [NC];
    logic signed [PSW-1:0]   pz_reg [NC][NC];
    logic signed [AP:0]      ad_reg [NC];
    logic signed [PSW-1:0]   plo_reg [NC];
    logic signed [PSW-1:0]   phi_reg [NC];
    logic                    area_nz_reg;
    logic signed [ASW-1:0]   area_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zx_reg[0] <= CW'(bbzo_pkg::RST_DL_X);
            zy_reg[0] <= CW'(bbzo_pkg::RST_DL_Y);
            zx_reg[1] <= CW'(bbzo_pkg::RST_DR_X);
            zy_reg[1] <= CW'(bbzo_pkg::RST_DR_Y);
            zx_reg[2] <= CW'(bbzo_pkg::RST_UR_X);
            zy_reg[2] <= CW'(bbzo_pkg::RST_UR_Y);
            zx_reg[3] <= CW'(bbzo_pkg::RST_UL_X);
            zy_reg[3] <= CW'(bbzo_pkg::RST_UL_Y);
        end
        else if (wr_en)
        begin
            unique case (bbzo_pkg::zone_reg_t'(wr_index))
                bbzo_pkg::REG_DL_X: zx_reg[0] <= wr_data;
                bbzo_pkg::REG_DL_Y: zy_reg[0] <= wr_data;
                bbzo_pkg::REG_DR_X: zx_reg[1] <= wr_data;
                bbzo_pkg::REG_DR_Y: zy_reg[1] <= wr_data;
                bbzo_pkg::REG_UR_X: zx_reg[2] <= wr_data;
                bbzo_pkg::REG_UR_Y: zy_reg[2] <= wr_data;
                bbzo_pkg::REG_UL_X: zx_reg[3] <= wr_data;
                bbzo_pkg::REG_UL_Y: zy_reg[3] <= wr_data;
            endcase
        end
    end

    // The normal of the edge from corner k to corner k+1 is (-(dy), dx).
    always_comb
    begin
        for (int k = 0; k < NC; k++)
        begin
            zxs[k] = signed'({1'b0, zx_reg[k]});
            zys[k] = signed'({1'b0, zy_reg[k]});
        end
        for (int k = 0; k < NC; k++)
        begin
            nx_next[k] = zys[k] - zys[(k + 1) % NC];
            ny_next[k] = zxs[(k + 1) % NC] - zxs[k];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NC; k++)
        begin
            nx_reg[k]   <= nx_next[k];
            ny_reg[k]   <= ny_next[k];
            live_reg[k] <= (nx_next[k] != '0) || (ny_next[k] != '0);
        end
        xlo_reg <= umin(umin(zx_reg[0], zx_reg[1]), umin(zx_reg[2], zx_reg[3]));
        xhi_reg <= umax(umax(zx_reg[0], zx_reg[1]), umax(zx_reg[2], zx_reg[3]));
        ylo_reg <= umin(umin(zy_reg[0], zy_reg[1]), umin(zy_reg[2], zy_reg[3]));
        yhi_reg <= umax(umax(zy_reg[0], zy_reg[1]), umax(zy_reg[2], zy_reg[3]));
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NC; k++)
        begin
            for (int i = 0; i < NC; i++)
            begin
                pzx_reg[k][i] <= PPW'(zxs[i]) * PPW'(nx_reg[k]);
                pzy_reg[k][i] <= PPW'(zys[i]) * PPW'(ny_reg[k]);
            end
        end
        for (int i = 0; i < NC; i++)
        begin
            ap_reg[i] <= AP'(zx_reg[i]) * AP'(zy_reg[(i + 1) % NC]);
            an_reg[i] <= AP'(zx_reg[(i + 1) % NC]) * AP'(zy_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NC; k++)
        begin
            for (int i = 0; i < NC; i++)
            begin
                pz_reg[k][i] <= PSW'(pzx_reg[k][i]) + PSW'(pzy_reg[k][i]);
            end
        end
        for (int i = 0; i < NC; i++)
        begin
            ad_reg[i] <= signed'((AP + 1)'(ap_reg[i]) - (AP + 1)'(an_reg[i]));
        end
    end

    assign area_sum = ASW'(ad_reg[0]) + ASW'(ad_reg[1]) + ASW'(ad_reg[2]) + ASW'(ad_reg[3]);

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NC; k++)
        begin
            plo_reg[k] <= smin(smin(pz_reg[k][0], pz_reg[k][1]),
                               smin(pz_reg[k][2], pz_reg[k][3]));
            phi_reg[k] <= smax(smax(pz_reg[k][0], pz_reg[k][1]),
                               smax(pz_reg[k][2], pz_reg[k][3]));
        end
        area_nz_reg <= (area_sum != '0);
    end

    assign x_lo      = xlo_reg;
    assign x_hi      = xhi_reg;
    assign y_lo      = ylo_reg;
    assign y_hi      = yhi_reg;
    assign norm_x    = nx_reg;
    assign norm_y    = ny_reg;
    assign edge_live = live_reg;
    assign proj_lo   = plo_reg;
    assign proj_hi   = phi_reg;
    assign area_nz   = area_nz_reg;

endmodule

// ===== design/bbzo_path.sv =====
// Object datapath of the zone overlap block: input, extrapolation, multiply,
// projection sum and result registers. Uses bbzo_pkg and the values from bbzo_zone.
module bbzo_path #(
    parameter int CW = bbzo_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 clk,
    input  bbzo_pkg::stage_ld_t                  ld,
    input  logic [bbzo_pkg::ID_WIDTH-1:0]        object_id,
    input  logic                                 is_car,
    input  logic signed [bbzo_pkg::SPEED_WIDTH-1:0] relative_speed,
    input  logic [CW-1:0]                        cur_x,
    input  logic [CW-1:0]                        cur_y,
    input  logic [CW-1:0]                        cur_w,
    input  logic [CW-1:0]                        cur_h,
    input  logic [CW-1:0]                        prev_x,
    input  logic [CW-1:0]                        prev_y,
    input  logic [CW-1:0]                        prev_w,
    input  logic [CW-1:0]                        prev_h,
    input  logic [CW-1:0]                        x_lo,
    input  logic [CW-1:0]                        x_hi,
    input  logic [CW-1:0]                        y_lo,
    input  logic [CW-1:0]                        y_hi,
    input  logic signed [CW:0]                   norm_x [bbzo_pkg::NUM_CORNERS],
    input  logic signed [CW:0]                   norm_y [bbzo_pkg::NUM_CORNERS],
    input  logic [bbzo_pkg::NUM_CORNERS-1:0]     edge_live,
    input  logic signed [2*CW+2:0]               proj_lo [bbzo_pkg::NUM_CORNERS],
    input  logic signed [2*CW+2:0]               proj_hi [bbzo_pkg::NUM_CORNERS],
    input  logic                                 area_nz,
    output logic [bbzo_pkg::ID_WIDTH-1:0]        result_id,
    output logic                                 approaching
);

    localparam int NC  = bbzo_pkg::NUM_CORNERS;
    localparam int IDW = bbzo_pkg::ID_WIDTH;
    localparam int EW  = CW + 1;
    localparam int CXW = CW + 2;
    localparam int BPW = 2 * CW + 3;
    localparam int BW  = 2 * CW + 5;

    // Next value is 2*cur - prev, and anything not positive becomes zero.
    function automatic logic [EW-1:0] extrap(input logic [CW-1:0] c, input logic [CW-1:0] p);
        logic signed [CW+1:0] v;
        v = signed'({1'b0, c, 1'b0}) - signed'({2'b00, p});
        return v[CW+1] ? '0 : v[CW:0];
    endfunction

    logic [IDW-1:0]          id0_reg, id1_reg, id2_reg, id3_reg, id4_reg;
    logic                    skip0_reg, skip1_reg, skip2_reg, skip3_reg;
    logic [CW-1:0]           cx0_reg, cy0_reg, cw0_reg, ch0_reg;
    logic [CW-1:0]           px0_reg, py0_reg, pw0_reg, ph0_reg;
    logic [EW-1:0]           x1_reg, y1_reg, w1_reg, h1_reg;
    logic signed [CXW-1:0]   xs1, ys1, ws1, hs1;
    logic [CXW-1:0]          xa2_reg, xb2_reg, ya2_reg, yb2_reg;
    logic                    nz2_reg, nz3_reg;
    logic signed [BPW-1:0]   ax2_reg [NC];
    logic signed [BPW-1:0]   ay2_reg [NC];
    logic signed [BPW-1:0]   aw2_reg [NC];
    logic signed [BPW-1:0]   ah2_reg [NC];
    logic signed [BW-1:0]    bmin_next [NC];
    logic signed [BW-1:0]    bmax_next [NC];
    logic signed [BW-1:0]    bmin3_reg [NC];
    logic signed [BW-1:0]    bmax3_reg [NC];
    logic                    axis_ok3_reg;
    logic [NC-1:0]           edge_ok;
    logic                    hit4_reg;

    always_ff @(posedge clk)
    begin
        if (ld.ld_in)
        begin
            id0_reg   <= object_id;
            skip0_reg <= is_car && !relative_speed[bbzo_pkg::SPEED_WIDTH-1];
            cx0_reg   <= cur_x;
            cy0_reg   <= cur_y;
            cw0_reg   <= cur_w;
            ch0_reg   <= cur_h;
            px0_reg   <= prev_x;
            py0_reg   <= prev_y;
            pw0_reg   <= prev_w;
            ph0_reg   <= prev_h;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.ld_ext)
        begin
            id1_reg   <= id0_reg;
            skip1_reg <= skip0_reg;
            x1_reg    <= extrap(cx0_reg, px0_reg);
            y1_reg    <= extrap(cy0_reg, py0_reg);
            w1_reg    <= extrap(cw0_reg, pw0_reg);
            h1_reg    <= extrap(ch0_reg, ph0_reg);
        end
    end

    assign xs1 = signed'({1'b0, x1_reg});
    assign ys1 = signed'({1'b0, y1_reg});
    assign ws1 = signed'({1'b0, w1_reg});
    assign hs1 = signed'({1'b0, h1_reg});

    always_ff @(posedge clk)
    begin
        if (ld.ld_mul)
        begin
            id2_reg   <= id1_reg;
            skip2_reg <= skip1_reg;
            nz2_reg   <= (w1_reg != '0) && (h1_reg != '0);
            xa2_reg   <= CXW'(x1_reg);
            xb2_reg   <= CXW'(x1_reg) + CXW'(w1_reg);
            ya2_reg   <= CXW'(y1_reg);
            yb2_reg   <= CXW'(y1_reg) + CXW'(h1_reg);
            for (int k = 0; k < NC; k++)
            begin
                ax2_reg[k] <= BPW'(xs1) * BPW'(norm_x[k]);
                ay2_reg[k] <= BPW'(ys1) * BPW'(norm_y[k]);
                aw2_reg[k] <= BPW'(ws1) * BPW'(norm_x[k]);
                ah2_reg[k] <= BPW'(hs1) * BPW'(norm_y[k]);
            end
        end
    end

    // The box projects onto a normal as the corner term plus the negative
    // (for the minimum) or positive (for the maximum) width and height terms.
    always_comb
    begin
        for (int k = 0; k < NC; k++)
        begin
            bmin_next[k] = BW'(ax2_reg[k]) + BW'(ay2_reg[k])
                         + (aw2_reg[k][BPW-1] ? BW'(aw2_reg[k]) : '0)
                         + (ah2_reg[k][BPW-1] ? BW'(ah2_reg[k]) : '0);
            bmax_next[k] = BW'(ax2_reg[k]) + BW'(ay2_reg[k])
                         + (aw2_reg[k][BPW-1] ? '0 : BW'(aw2_reg[k]))
                         + (ah2_reg[k][BPW-1] ? '0 : BW'(ah2_reg[k]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.ld_sum)
        begin
            id3_reg      <= id2_reg;
            skip3_reg    <= skip2_reg;
            nz3_reg      <= nz2_reg;
            axis_ok3_reg <= (CXW'(x_hi) > xa2_reg) && (xb2_reg > CXW'(x_lo))
                         && (CXW'(y_hi) > ya2_reg) && (yb2_reg > CXW'(y_lo));
            for (int k = 0; k < NC; k++)
            begin
                bmin3_reg[k] <= bmin_next[k];
                bmax3_reg[k] <= bmax_next[k];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NC; k++)
        begin
            edge_ok[k] = !edge_live[k]
                      || ((BW'(proj_hi[k]) > bmin3_reg[k]) && (bmax3_reg[k] > BW'(proj_lo[k])));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.ld_out)
        begin
            id4_reg  <= id3_reg;
            hit4_reg <= !skip3_reg && nz3_reg && area_nz && axis_ok3_reg && (&edge_ok);
        end
    end

    assign result_id   = id4_reg;
    assign approaching = hit4_reg;

endmodule

// ===== design/bbox_extrapolate_zone_overlap.sv =====
// Top level of the zone overlap block: handshake control of the five-stage
// object pipeline. Uses bbzo_pkg, bbzo_zone and bbzo_path.
//
// Channel  Handshake                  Payload                         Transfer
// item     item_valid, item_stall     object_id .. prev_h             valid && !stall
// result   result_valid, result_stall result_id, approaching          valid && !stall
// config   wr_en                      wr_index, wr_data               wr_en
//
// One item is taken per cycle while item_stall is low; the input register takes an item at its
// transfer edge and it then passes through the extrapolation, multiply, sum and result
// registers in that order, after which its result is offered.
// Zone values follow a register write through a four-register chain and are
// ready for any item transferred from the next cycle on.
// Reset clears the stage valid bits and loads the default zone corners.
// A stalled result lets the stages behind it close up; item_stall rises only
// when all five stages hold items and the result is stalled.
module bbox_extrapolate_zone_overlap #(
    parameter int COORD_WIDTH = bbzo_pkg::COORD_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    item_valid,
    output logic                                    item_stall,
    input  logic [bbzo_pkg::ID_WIDTH-1:0]           object_id,
    input  logic                                    is_car,
    input  logic signed [bbzo_pkg::SPEED_WIDTH-1:0] relative_speed,
    input  logic [COORD_WIDTH-1:0]                  cur_x,
    input  logic [COORD_WIDTH-1:0]                  cur_y,
    input  logic [COORD_WIDTH-1:0]                  cur_w,
    input  logic [COORD_WIDTH-1:0]                  cur_h,
    input  logic [COORD_WIDTH-1:0]                  prev_x,
    input  logic [COORD_WIDTH-1:0]                  prev_y,
    input  logic [COORD_WIDTH-1:0]                  prev_w,
    input  logic [COORD_WIDTH-1:0]                  prev_h,
    output logic                                    result_valid,
    input  logic                                    result_stall,
    output logic [bbzo_pkg::ID_WIDTH-1:0]           result_id,
    output logic                                    approaching,
    input  logic                                    wr_en,
    input  logic [bbzo_pkg::REG_IDX_WIDTH-1:0]      wr_index,
    input  logic [COORD_WIDTH-1:0]                  wr_data
);

    localparam int NS = bbzo_pkg::NUM_STAGES;
    localparam int NC = bbzo_pkg::NUM_CORNERS;
    localparam int CW = COORD_WIDTH;

    logic [NS-1:0]           vld_reg;
    logic [NS-1:0]           vld_next;
    logic [NS-1:0]           ready;
    bbzo_pkg::stage_ld_t     ld;

    logic [CW-1:0]           x_lo, x_hi, y_lo, y_hi;
    logic signed [CW:0]      norm_x [NC];
    logic signed [CW:0]      norm_y [NC];
    logic [NC-1:0]           edge_live;
    logic signed [2*CW+2:0]  proj_lo [NC];
    logic signed [2*CW+2:0]  proj_hi [NC];
    logic                    area_nz;

    // A stage can take new data when it is empty or its content moves on.
    always_comb
    begin
        ready[NS-1] = !vld_reg[NS-1] || !result_stall;
        for (int k = NS - 2; k >= 0; k--)
        begin
            ready[k] = !vld_reg[k] || ready[k+1];
        end
    end

    always_comb
    begin
        vld_next[0] = ready[0] ? item_valid : vld_reg[0];
        for (int k = 1; k < NS; k++)
        begin
            vld_next[k] = ready[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_comb
    begin
        ld.ld_in  = ready[0] && item_valid;
        ld.ld_ext = ready[1] && vld_reg[0];
        ld.ld_mul = ready[2] && vld_reg[1];
        ld.ld_sum = ready[3] && vld_reg[2];
        ld.ld_out = ready[4] && vld_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign item_stall   = !ready[0];
    assign result_valid = vld_reg[NS-1];

    bbzo_zone #(
        .CW        (CW)
    ) u_zone (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .x_lo      (x_lo),
        .x_hi      (x_hi),
        .y_lo      (y_lo),
        .y_hi      (y_hi),
        .norm_x    (norm_x),
        .norm_y    (norm_y),
        .edge_live (edge_live),
        .proj_lo   (proj_lo),
        .proj_hi   (proj_hi),
        .area_nz   (area_nz)
    );

    bbzo_path #(
        .CW             (CW)
    ) u_path (
        .clk            (clk),
        .ld             (ld),
        .object_id      (object_id),
        .is_car         (is_car),
        .relative_speed (relative_speed),
        .cur_x          (cur_x),
        .cur_y          (cur_y),
        .cur_w          (cur_w),
        .cur_h          (cur_h),
        .prev_x         (prev_x),
        .prev_y         (prev_y),
        .prev_w         (prev_w),
        .prev_h         (prev_h),
        .x_lo           (x_lo),
        .x_hi           (x_hi),
        .y_lo           (y_lo),
        .y_hi           (y_hi),
        .norm_x         (norm_x),
        .norm_y         (norm_y),
        .edge_live      (edge_live),
        .proj_lo        (proj_lo),
        .proj_hi        (proj_hi),
        .area_nz        (area_nz),
        .result_id      (result_id),
        .approaching    (approaching)
    );

endmodule

// ===== design/bbzo_check.sv =====
// Port-level checks of the zone overlap block, bound to its top level.
// Uses bbzo_pkg and the assertion macros of bbox_extrapolate_zone_overlap_assert.svh.
`include "bbox_extrapolate_zone_overlap_assert.svh"

module bbzo_check (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    item_valid,
    input logic                                    item_stall,
    input logic [bbzo_pkg::ID_WIDTH-1:0]           object_id,
    input logic                                    is_car,
    input logic signed [bbzo_pkg::SPEED_WIDTH-1:0] relative_speed,
    input logic                                    result_valid,
    input logic                                    result_stall,
    input logic [bbzo_pkg::ID_WIDTH-1:0]           result_id,
    input logic                                    approaching
);

    `BBZO_ASSERT_NEXT(a_result_holds, clk, rst_n, result_valid && result_stall, result_valid && $stable(result_id) && $stable(approaching))
    `BBZO_ASSERT_NOW(a_result_drops_by_transfer, clk, rst_n, $fell(result_valid), $past(!result_stall))
    `BBZO_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, item_stall, result_valid && result_stall)
    `BBZO_ASSERT_NEXT(a_skipped_car_passes, clk, rst_n, (item_valid && !item_stall && is_car && !relative_speed[bbzo_pkg::SPEED_WIDTH-1] ##1 !result_stall ##1 !result_stall ##1 !result_stall ##1 !result_stall), result_valid && !approaching && (result_id == $past(object_id, 5)))

endmodule

bind bbox_extrapolate_zone_overlap bbzo_check u_check (.*);
